// File: design/lbns_pkg.sv
// Shared constants and word types for the letterbox nearest-neighbor address mapper.
package lbns_pkg;

   localparam int OUT_WIDTH   = 320;
   localparam int OUT_HEIGHT  = 240;
   localparam int MAX_SRC_DIM = 4096;

   localparam int DIM_W    = 13;
   localparam int COL_W    = 9;
   localparam int ROW_W    = 8;
   localparam int SRC_W    = 12;
   localparam int IDX_W    = 24;
   localparam int PROD_W   = 22;
   localparam int RECIP_SH = 32;
   localparam int RECIP_W  = 25;
   localparam int QUO_W    = PROD_W + RECIP_W - RECIP_SH;
   localparam int DIV_CNT_W = 5;

   localparam logic [RECIP_W-1:0] RECIP_COL = RECIP_W'((64'd1 << RECIP_SH) / OUT_WIDTH);
   localparam logic [RECIP_W-1:0] RECIP_ROW = RECIP_W'((64'd1 << RECIP_SH) / OUT_HEIGHT);

   localparam logic [0:0] REG_SOURCE_WIDTH  = 1'b0;
   localparam logic [0:0] REG_SOURCE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [COL_W-1:0] out_col;
      logic [ROW_W-1:0] out_row;
   } req_type;

   typedef struct packed {
      logic             inside_image;
      logic [SRC_W-1:0] src_col;
      logic [SRC_W-1:0] src_row;
      logic [IDX_W-1:0] src_index;
   } rsp_type;

   typedef struct packed {
      logic             busy;
      logic             blank;
      logic             wide_fit;
      logic [COL_W-1:0] ox;
      logic [ROW_W-1:0] oy;
      logic [COL_W:0]   col_end;
      logic [ROW_W:0]   row_end;
   } setup_type;

endpackage

// File: design/letterbox_nearest_scaler_addr.sv
// Top level of the letterbox nearest-neighbor address mapper.
// Each input word carries one display coordinate (out_col, out_row) and is taken at a
// clock edge where start is high and busy is low. Each one yields exactly one result word
// on rsp_word, shown for one cycle with rsp_strobe high, after it has passed the five register stages.
// While busy is low a new coordinate can be taken every cycle, so the mapper sustains
// one word per clock through its five register stages.
// Writing source_width or source_height through the csr port raises busy while a
// one-bit-per-cycle divider works out the drawn size and bar offsets; busy stays high until the
// setup has returned to idle, and the same pass runs after reset with the default 320 by
// 240 source.
// Reset clears the pipeline valid bits, so no result word appears from before reset.
// Result words cannot be held off, so the pipeline never stalls once a word is accepted.
// Pixels in a bar, or any pixel when the fit leaves nothing drawn, report inside_image
// low with zero coordinates and index.
module letterbox_nearest_scaler_addr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lbns_pkg::req_type          req_word,
   output logic                       rsp_strobe,
   output lbns_pkg::rsp_type          rsp_word,
   input  logic                       csr_write_en,
   input  logic [0:0]                 csr_index,
   input  logic [lbns_pkg::DIM_W-1:0] csr_wdata
);

   lbns_pkg::setup_type                 setup;
   logic [lbns_pkg::DIM_W-1:0]          sw_ff, sh_ff, wdata_sat;
   logic [lbns_pkg::DIM_W-1:0]          num;
   logic [lbns_pkg::RECIP_W-1:0]        recip;
   logic [lbns_pkg::COL_W-1:0]          den;
   logic                                accept;

   logic                                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                                in1_ff, in2_ff, in3_ff, in4_ff;
   logic [lbns_pkg::COL_W-1:0]          x1_ff;
   logic [lbns_pkg::ROW_W-1:0]          y1_ff;
   logic [lbns_pkg::PROD_W-1:0]         px2_ff, py2_ff, px3_ff, py3_ff;
   logic [lbns_pkg::QUO_W-1:0]          qx3_ff, qy3_ff;
   logic [lbns_pkg::SRC_W-1:0]          sx4_ff, sy4_ff;
   lbns_pkg::rsp_type                   rsp_ff, rsp_in;

   logic                                in1_in;
   logic [lbns_pkg::PROD_W+lbns_pkg::RECIP_W-1:0] mx, my;
   logic [lbns_pkg::PROD_W-1:0]         rx, ry;
   logic [lbns_pkg::QUO_W-1:0]          fx, fy;
   logic [lbns_pkg::SRC_W-1:0]          sx_in, sy_in;
   logic [lbns_pkg::IDX_W:0]            idx;

   lbns_setup u_setup (
      .clock  (clock),
      .reset  (reset),
      .recalc (csr_write_en),
      .src_w  (sw_ff),
      .src_h  (sh_ff),
      .setup  (setup)
   );

   assign busy   = setup.busy;
   assign accept = start && !setup.busy;
   assign wdata_sat = (csr_wdata > lbns_pkg::DIM_W'(lbns_pkg::MAX_SRC_DIM)) ?
                      lbns_pkg::DIM_W'(lbns_pkg::MAX_SRC_DIM) : csr_wdata;

   always_comb begin
      num   = setup.wide_fit ? sw_ff : sh_ff;
      recip = setup.wide_fit ? lbns_pkg::RECIP_COL : lbns_pkg::RECIP_ROW;
      den   = setup.wide_fit ? lbns_pkg::COL_W'(lbns_pkg::OUT_WIDTH) :
                               lbns_pkg::COL_W'(lbns_pkg::OUT_HEIGHT);
      in1_in = !setup.blank &&
               (req_word.out_col >= setup.ox) &&
               ({1'b0, req_word.out_col} < setup.col_end) &&
               (req_word.out_row >= setup.oy) &&
               ({1'b0, req_word.out_row} < setup.row_end);

      mx = (lbns_pkg::PROD_W+lbns_pkg::RECIP_W)'(px2_ff) * (lbns_pkg::PROD_W+lbns_pkg::RECIP_W)'(recip);
      my = (lbns_pkg::PROD_W+lbns_pkg::RECIP_W)'(py2_ff) * (lbns_pkg::PROD_W+lbns_pkg::RECIP_W)'(recip);

      rx = px3_ff - lbns_pkg::PROD_W'(qx3_ff) * lbns_pkg::PROD_W'(den);
      ry = py3_ff - lbns_pkg::PROD_W'(qy3_ff) * lbns_pkg::PROD_W'(den);
      fx = (rx >= lbns_pkg::PROD_W'(den)) ? qx3_ff + 1'b1 : qx3_ff;
      fy = (ry >= lbns_pkg::PROD_W'(den)) ? qy3_ff + 1'b1 : qy3_ff;
      sx_in = (fx >= lbns_pkg::QUO_W'(sw_ff)) ? lbns_pkg::SRC_W'(sw_ff - 1'b1) :
                                                 lbns_pkg::SRC_W'(fx);
      sy_in = (fy >= lbns_pkg::QUO_W'(sh_ff)) ? lbns_pkg::SRC_W'(sh_ff - 1'b1) :
                                                 lbns_pkg::SRC_W'(fy);

      idx = (lbns_pkg::IDX_W+1)'(sy4_ff) * (lbns_pkg::IDX_W+1)'(sw_ff) +
            (lbns_pkg::IDX_W+1)'(sx4_ff);
      rsp_in.inside_image = in4_ff;
      rsp_in.src_col      = in4_ff ? sx4_ff : '0;
      rsp_in.src_row      = in4_ff ? sy4_ff : '0;
      rsp_in.src_index    = in4_ff ? idx[lbns_pkg::IDX_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= lbns_pkg::DIM_W'(lbns_pkg::OUT_WIDTH);
         sh_ff <= lbns_pkg::DIM_W'(lbns_pkg::OUT_HEIGHT);
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (csr_write_en && (csr_index == lbns_pkg::REG_SOURCE_WIDTH)) begin
            sw_ff <= wdata_sat;
         end
         if (csr_write_en && (csr_index == lbns_pkg::REG_SOURCE_HEIGHT)) begin
            sh_ff <= wdata_sat;
         end
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      in1_ff <= in1_in;
      x1_ff  <= req_word.out_col - setup.ox;
      y1_ff  <= req_word.out_row - setup.oy;
      in2_ff <= in1_ff;
      px2_ff <= lbns_pkg::PROD_W'(x1_ff) * lbns_pkg::PROD_W'(num);
      py2_ff <= lbns_pkg::PROD_W'(y1_ff) * lbns_pkg::PROD_W'(num);
      in3_ff <= in2_ff;
      px3_ff <= px2_ff;
      py3_ff <= py2_ff;
      qx3_ff <= mx[lbns_pkg::PROD_W+lbns_pkg::RECIP_W-1:lbns_pkg::RECIP_SH];
      qy3_ff <= my[lbns_pkg::PROD_W+lbns_pkg::RECIP_W-1:lbns_pkg::RECIP_SH];
      in4_ff <= in3_ff;
      sx4_ff <= sx_in;
      sy4_ff <= sy_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = v5_ff;
   assign rsp_word   = rsp_ff;

   a_black_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.inside_image) |->
         (rsp_word.src_col == '0) && (rsp_word.src_row == '0) && (rsp_word.src_index == '0))
      else $error("black bar word carries a nonzero address");
   a_col_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.inside_image) |->
         ({1'b0, rsp_word.src_col} < sw_ff) && ({1'b0, rsp_word.src_row} < sh_ff))
      else $error("source coordinate beyond the source image");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && busy) |=> !v1_ff)
      else $error("word taken while busy");

endmodule

// File: design/lbns_setup.sv
// Geometry sequencer: derives the fit mode, drawn size and bar offsets from the source size.
module lbns_setup (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       recalc,
   input  logic [lbns_pkg::DIM_W-1:0] src_w,
   input  logic [lbns_pkg::DIM_W-1:0] src_h,
   output lbns_pkg::setup_type        setup
);

   typedef enum logic [1:0] {ST_CALC, ST_DIV, ST_DONE, ST_IDLE} state_type;

   state_type                          state_ff, state_in;
   logic                               wide_ff, wide_in;
   logic                               zero_ff, zero_in;
   logic [lbns_pkg::DIM_W-1:0]         divisor_ff, divisor_in;
   logic [lbns_pkg::PROD_W-1:0]        dvd_ff, dvd_in;
   logic [lbns_pkg::DIM_W:0]           rem_ff, rem_in;
   logic [lbns_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   lbns_pkg::setup_type                geo_ff, geo_in;

   logic [lbns_pkg::DIM_W:0]           rem_shift;
   logic [lbns_pkg::PROD_W-1:0]        prod_w, prod_h;
   logic [lbns_pkg::COL_W-1:0]         dw;
   logic [lbns_pkg::ROW_W:0]           dh;
   logic [lbns_pkg::COL_W-1:0]         quo_c;
   logic [lbns_pkg::ROW_W:0]           quo_r;

   always_comb begin
      prod_w    = lbns_pkg::PROD_W'(src_h) * lbns_pkg::PROD_W'(lbns_pkg::OUT_WIDTH);
      prod_h    = lbns_pkg::PROD_W'(src_w) * lbns_pkg::PROD_W'(lbns_pkg::OUT_HEIGHT);
      rem_shift = {rem_ff[lbns_pkg::DIM_W-1:0], dvd_ff[lbns_pkg::PROD_W-1]};
      quo_c     = dvd_ff[lbns_pkg::COL_W-1:0];
      quo_r     = dvd_ff[lbns_pkg::ROW_W:0];
      if (wide_ff) begin
         dw = lbns_pkg::COL_W'(lbns_pkg::OUT_WIDTH);
         dh = quo_r;
      end else begin
         dw = quo_c;
         dh = (lbns_pkg::ROW_W+1)'(lbns_pkg::OUT_HEIGHT);
      end

      state_in   = state_ff;
      wide_in    = wide_ff;
      zero_in    = zero_ff;
      divisor_in = divisor_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      geo_in     = geo_ff;
      geo_in.busy = 1'b1;

      case (state_ff)
         ST_CALC: begin
            wide_in = (prod_w <= prod_h);
            zero_in = (src_w == '0) || (src_h == '0);
            if (prod_w <= prod_h) begin
               dvd_in     = prod_w;
               divisor_in = src_w;
            end else begin
               dvd_in     = prod_h;
               divisor_in = src_h;
            end
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ((src_w == '0) || (src_h == '0)) ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (rem_shift >= {1'b0, divisor_ff}) begin
               rem_in = rem_shift - {1'b0, divisor_ff};
               dvd_in = {dvd_ff[lbns_pkg::PROD_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               dvd_in = {dvd_ff[lbns_pkg::PROD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lbns_pkg::DIV_CNT_W'(lbns_pkg::PROD_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            geo_in.wide_fit = wide_ff;
            geo_in.blank    = zero_ff || (dw == '0) || (dh == '0);
            geo_in.ox       = lbns_pkg::COL_W'((lbns_pkg::COL_W'(lbns_pkg::OUT_WIDTH) - dw) >> 1);
            geo_in.oy       = lbns_pkg::ROW_W'(((lbns_pkg::ROW_W+1)'(lbns_pkg::OUT_HEIGHT) - dh) >> 1);
            geo_in.col_end  = {1'b0, geo_in.ox} + {1'b0, dw};
            geo_in.row_end  = {1'b0, geo_in.oy} + dh;
            state_in        = ST_IDLE;
         end
         ST_IDLE: begin
            geo_in.busy = 1'b0;
         end
         default: begin
            state_in = ST_CALC;
         end
      endcase

      if (recalc) begin
         state_in    = ST_CALC;
         geo_in.busy = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CALC;
         geo_ff.busy <= 1'b1;
         geo_ff.blank <= 1'b1;
      end else begin
         state_ff    <= state_in;
         geo_ff.busy <= geo_in.busy;
         geo_ff.blank <= geo_in.blank;
      end
      wide_ff         <= wide_in;
      zero_ff         <= zero_in;
      divisor_ff      <= divisor_in;
      dvd_ff          <= dvd_in;
      rem_ff          <= rem_in;
      cnt_ff          <= cnt_in;
      geo_ff.wide_fit <= geo_in.wide_fit;
      geo_ff.ox       <= geo_in.ox;
      geo_ff.oy       <= geo_in.oy;
      geo_ff.col_end  <= geo_in.col_end;
      geo_ff.row_end  <= geo_in.row_end;
   end

   assign setup = geo_ff;

   a_busy_not_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> geo_ff.busy || $past(state_ff == ST_DONE && !recalc))
      else $error("setup reported ready while still working");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < lbns_pkg::DIV_CNT_W'(lbns_pkg::PROD_W)))
      else $error("divider ran past its last bit");
   a_recalc: assert property (@(posedge clock) disable iff (reset)
      recalc |=> (state_ff == ST_CALC) && geo_ff.busy)
      else $error("register write did not restart the setup");

endmodule

// File: tb/letterbox_nearest_scaler_addr_checker.sv
// Checker that predicts the mapped source address for each coordinate word and compares it.
module letterbox_nearest_scaler_addr_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  lbns_pkg::req_type          req_word,
   input  logic                       rsp_strobe,
   input  lbns_pkg::rsp_type          rsp_word,
   input  logic                       csr_write_en,
   input  logic [0:0]                 csr_index,
   input  logic [lbns_pkg::DIM_W-1:0] csr_wdata,
   output int                         error_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [lbns_pkg::DIM_W-1:0] model_width = 13'd320;
   logic [lbns_pkg::DIM_W-1:0] model_height = 13'd240;
   lbns_pkg::rsp_type expected_words[$];

   assign pending_count = expected_words.size();

   function automatic lbns_pkg::rsp_type map_coordinate(lbns_pkg::req_type w);
      lbns_pkg::rsp_type r;
      longint unsigned sw, sh, dw, dh, ox, oy, num, den, x, y, sx, sy, col, row;
      longint unsigned ow, oh, lim;
      r = '0;
      ow = lbns_pkg::OUT_WIDTH;
      oh = lbns_pkg::OUT_HEIGHT;
      lim = lbns_pkg::MAX_SRC_DIM;
      sw = (model_width > lim) ? lim : 64'(model_width);
      sh = (model_height > lim) ? lim : 64'(model_height);
      col = 64'(w.out_col);
      row = 64'(w.out_row);
      if (sw == 0 || sh == 0) return r;
      if (ow * sh <= oh * sw) begin
         dw = ow;
         dh = (sh * ow) / sw;
         num = sw;
         den = ow;
      end else begin
         dh = oh;
         dw = (sw * oh) / sh;
         num = sh;
         den = oh;
      end
      ox = (ow - dw) / 2;
      oy = (oh - dh) / 2;
      if (dw == 0 || dh == 0 || col < ox || col >= ox + dw || row < oy || row >= oy + dh)
         return r;
      x = col - ox;
      y = row - oy;
      sx = (x * num) / den;
      sy = (y * num) / den;
      if (sx >= sw) sx = sw - 1;
      if (sy >= sh) sy = sh - 1;
      r.inside_image = 1'b1;
      r.src_col = sx[lbns_pkg::SRC_W-1:0];
      r.src_row = sy[lbns_pkg::SRC_W-1:0];
      r.src_index = lbns_pkg::IDX_W'(sy * sw + sx);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      lbns_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", 64'(rsp_word), 0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.inside_image !== want.inside_image)
                  report_mismatch("inside_image", rsp_word.inside_image, want.inside_image);
               if (rsp_word.src_col !== want.src_col)
                  report_mismatch("src_col", rsp_word.src_col, want.src_col);
               if (rsp_word.src_row !== want.src_row)
                  report_mismatch("src_row", rsp_word.src_row, want.src_row);
               if (rsp_word.src_index !== want.src_index)
                  report_mismatch("src_index", rsp_word.src_index, want.src_index);
            end
         end
         if (start && !busy) expected_words.push_back(map_coordinate(req_word));
         if (csr_write_en) begin
            if (csr_index == lbns_pkg::REG_SOURCE_WIDTH) model_width <= csr_wdata;
            else model_height <= csr_wdata;
         end
      end
   end
endmodule

// File: tb/letterbox_nearest_scaler_addr_tb.sv
// Testbench top: drives coordinate words and source sizes, and gives the verdict.
module letterbox_nearest_scaler_addr_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   lbns_pkg::req_type req_word = '0;
   logic rsp_strobe;
   lbns_pkg::rsp_type rsp_word;
   logic csr_write_en = 1'b0;
   logic [0:0] csr_index = lbns_pkg::REG_SOURCE_WIDTH;
   logic [lbns_pkg::DIM_W-1:0] csr_wdata = '0;
   int error_count;
   int pending_count;
   int idle_percent = 0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   letterbox_nearest_scaler_addr u_top (.*);

   letterbox_nearest_scaler_addr_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[letterbox_nearest_scaler_addr] ERROR");
         $finish;
      end
   end

   task automatic send_word(logic [lbns_pkg::COL_W-1:0] col,
                            logic [lbns_pkg::ROW_W-1:0] row);
      while (idle_percent > 0 && $urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= '{out_col: col, out_row: row};
      do @(posedge clock); while (busy);
   endtask

   task automatic write_size(logic [lbns_pkg::DIM_W-1:0] width,
                             logic [lbns_pkg::DIM_W-1:0] height);
      start <= 1'b0;
      wait (pending_count == 0);
      repeat (8) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= lbns_pkg::REG_SOURCE_WIDTH;
      csr_wdata <= width;
      @(posedge clock);
      csr_index <= lbns_pkg::REG_SOURCE_HEIGHT;
      csr_wdata <= height;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_random(int count);
      repeat (count) begin
         if ($urandom_range(3) == 0)
            send_word(lbns_pkg::COL_W'($urandom), lbns_pkg::ROW_W'($urandom));
         else
            send_word(lbns_pkg::COL_W'($urandom_range(lbns_pkg::OUT_WIDTH - 1)),
                      lbns_pkg::ROW_W'($urandom_range(lbns_pkg::OUT_HEIGHT - 1)));
      end
   endtask

   initial begin
      logic [lbns_pkg::DIM_W-1:0] sizes[12][2] = '{'{320, 240}, '{1, 1}, '{4096, 4096},
         '{8191, 8191}, '{0, 240}, '{320, 0}, '{4096, 1}, '{1, 4096}, '{640, 120},
         '{100, 400}, '{5000, 37}, '{321, 241}};
      int phase_idle[4] = '{0, 88, 0, 31};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
      send_word(9'd0, 8'd0);
      send_word(lbns_pkg::COL_W'(lbns_pkg::OUT_WIDTH - 1),
                lbns_pkg::ROW_W'(lbns_pkg::OUT_HEIGHT - 1));
      send_word(9'h1FF, 8'hFF);
      send_word(lbns_pkg::COL_W'(lbns_pkg::OUT_WIDTH), 8'd0);
      send_word(9'd0, lbns_pkg::ROW_W'(lbns_pkg::OUT_HEIGHT));
      send_word(9'd160, 8'd120);
      for (int i = 0; i < 12; i++) begin
         write_size(sizes[i][0], sizes[i][1]);
         idle_percent = phase_idle[i % 4];
         send_word(9'd0, 8'd0);
         send_word(lbns_pkg::COL_W'(lbns_pkg::OUT_WIDTH - 1),
                   lbns_pkg::ROW_W'(lbns_pkg::OUT_HEIGHT - 1));
         send_random(70);
      end
      write_size(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      send_random(60);
      start <= 1'b0;
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("[letterbox_nearest_scaler_addr] OK");
      else $display("[letterbox_nearest_scaler_addr] ERROR");
      $finish;
   end
endmodule
